/* hw/rtl/mfpl_pkg.sv */
// Shared types and constants for the monochrome framebuffer draw unit.
// Used by mfpl_div, mfpl_store and mono_framebuffer_point_line_draw_unit.
package mfpl_pkg;

    localparam int STORE_PAGES = 8;
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = 10;
    localparam int COL_W       = 7;
    localparam int PAGE_W      = 3;
    localparam int DIV_W       = 8;

    localparam logic [7:0] BYTE_FULL  = 8'hff;
    localparam logic [7:0] BYTE_EMPTY = 8'h00;

    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [1:0] PEN_ERASE  = 2'd0;
    localparam logic [1:0] PEN_SET    = 2'd1;
    localparam logic [1:0] PEN_INVERT = 2'd2;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_DIV,
        S_PIX_RD,
        S_PIX_WR,
        S_READ_RD,
        S_READ_WAIT,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MEM_NOP,
        MEM_READ,
        MEM_WRITE,
        MEM_MODIFY
    } mem_op_t;

    typedef struct packed {
        mem_op_t           op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [1:0]        pen;
    } mem_cmd_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } div_res_t;

endpackage

/* hw/rtl/mfpl_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on mfpl_pkg (DIV_W, div_res_t).
module mfpl_div
    import mfpl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output div_res_t         res
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [DIV_W:0]   trial;
    logic             fits;

    // Shift in the next dividend bit and subtract when it fits.
    always_comb
    begin
        trial      = {rem_reg, quo_reg[DIV_W-1]};
        fits       = trial >= {1'b0, den_reg};
        count_next = count_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        if (start)
        begin
            count_next = CNT_W'(DIV_W);
            rem_next   = '0;
            quo_next   = dividend;
            den_next   = divisor;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == CNT_W'(1));
            rem_next   = fits ? DIV_W'(trial - {1'b0, den_reg}) : trial[DIV_W-1:0];
            quo_next   = {quo_reg[DIV_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;
    assign res.rem  = rem_reg;

endmodule

/* hw/rtl/mfpl_store.sv */
// Page-byte frame memory with registered read and pen read-modify-write.
// Depends on mfpl_pkg (mem_cmd_t, STORE_DEPTH, pen codes).
module mfpl_store
    import mfpl_pkg::*;
(
    input  logic       clk,
    input  mem_cmd_t   cmd,
    output logic [7:0] rd_data
);

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;
    logic [7:0] merged;

    // Apply the pen mask to the byte fetched in the previous cycle.
    always_comb
    begin
        unique case (cmd.pen)
            PEN_SET:    merged = rd_data_reg | cmd.data;
            PEN_INVERT: merged = rd_data_reg ^ cmd.data;
            default:    merged = rd_data_reg & ~cmd.data;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            MEM_WRITE:  mem[cmd.addr] <= cmd.data;
            MEM_MODIFY: mem[cmd.addr] <= merged;
            MEM_READ:   rd_data_reg   <= mem[cmd.addr];
            default:    ;
        endcase
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/mono_framebuffer_point_line_draw_unit.sv */
// Sequence: a point or each visible line pixel is read and then written back, an
// off-screen pixel is only stepped over, a sloped line first waits for the slope
// divider, a read fetches one byte, and each transaction hands over its result.
// One transaction at a time; the single-port frame memory and its per-pixel
// read-modify-write set the pace; a fill sweeps all 1024 bytes. Reset: asynchronous,
// active low; afterwards a clearing pass zeroes the memory with item_ready low.
module mono_framebuffer_point_line_draw_unit
    import mfpl_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [1:0] kind,
    input  logic [7:0] xa,
    input  logic [7:0] ya,
    input  logic [7:0] xb,
    input  logic [7:0] yb,
    input  logic [1:0] pen,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] read_byte
);

    localparam int READ_PAGES = (SCREEN_HEIGHT + 7) / 8;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              sweep_item_reg, sweep_item_next;
    logic [7:0]        fill_data_reg, fill_data_next;
    logic              result_valid_reg, result_valid_next;

    logic [1:0] pen_reg, pen_next;
    logic       walk_row_reg, walk_row_next;
    logic [7:0] cur_x_reg, cur_x_next;
    logic [7:0] cur_y_reg, cur_y_next;
    logic [7:0] end_reg, end_next;
    logic [7:0] ya_reg, ya_next;
    logic [9:0] q_reg, q_next;          // two's complement row offset from ya
    logic [7:0] r_reg, r_next;          // remainder, always below dx
    logic [7:0] dx_reg, dx_next;
    logic [9:0] stepq_reg, stepq_next;
    logic [7:0] stepr_reg, stepr_next;
    logic       dy_neg_reg, dy_neg_next;
    logic [7:0] result_reg, result_next;
    logic [7:0] read_byte_reg, read_byte_next;

    logic       accept;
    logic [7:0] x_lo, x_hi, y_lo, y_hi;
    logic [8:0] dy_in;
    logic [7:0] dy_abs;
    logic       sloped;
    logic       read_ok;
    logic       fill_write;
    logic       div_start;
    div_res_t   div_res;

    logic [9:0] py;
    logic       visible;
    logic       walk_last;
    logic [8:0] r_sum;
    logic       wrap;
    logic [7:0] r_adv;
    logic [9:0] q_adv;
    logic       out_free;

    mem_cmd_t   mem_cmd;
    logic [7:0] rd_data;

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign read_byte    = read_byte_reg;
    assign out_free     = !result_valid_reg || result_ready;

    // Decode the incoming transaction: line endpoints ordered by column, dy taken in that order, read bounds, fill pen.
    always_comb
    begin
        x_lo       = (xa < xb) ? xa : xb;
        x_hi       = (xa < xb) ? xb : xa;
        y_lo       = (ya < yb) ? ya : yb;
        y_hi       = (ya < yb) ? yb : ya;
        dy_in      = (xa < xb) ? ({1'b0, yb} - {1'b0, ya}) : ({1'b0, ya} - {1'b0, yb});
        dy_abs     = dy_in[8] ? 8'(9'd0 - dy_in) : dy_in[7:0];
        sloped     = (xa != xb) && (ya != yb);
        read_ok    = ({1'b0, xa} < 9'(SCREEN_WIDTH)) && ({1'b0, ya} < 9'(READ_PAGES));
        fill_write = (pen == PEN_SET) || (pen == PEN_ERASE);
        div_start  = accept && (kind == KIND_LINE) && sloped;
    end

    // Current pixel and the exact rational step to the next column:
    // q advances by floor(dy/dx), r by the remainder, with one carry into q.
    always_comb
    begin
        py        = walk_row_reg ? {2'b00, cur_y_reg} : ({2'b00, ya_reg} + q_reg);
        visible   = !py[9] && (py < 10'(SCREEN_HEIGHT))
                    && ({1'b0, cur_x_reg} < 9'(SCREEN_WIDTH));
        walk_last = walk_row_reg ? (cur_y_reg == end_reg) : (cur_x_reg == end_reg);
        r_sum     = {1'b0, r_reg} + {1'b0, stepr_reg};
        wrap      = r_sum >= {1'b0, dx_reg};
        r_adv     = wrap ? 8'(r_sum - {1'b0, dx_reg}) : r_sum[7:0];
        q_adv     = q_reg + stepq_reg + {9'd0, wrap};
    end

    mfpl_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dy_abs),
        .divisor  (x_hi - x_lo),
        .res      (div_res)
    );

    mfpl_store u_store
    (
        .clk     (clk),
        .cmd     (mem_cmd),
        .rd_data (rd_data)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_SWEEP:
            begin
                if (sweep_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = sweep_item_reg ? S_FINISH : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        KIND_POINT: state_next = S_PIX_RD;
                        KIND_LINE:  state_next = sloped ? S_DIV : S_PIX_RD;
                        KIND_FILL:  state_next = fill_write ? S_SWEEP : S_FINISH;
                        default:    state_next = read_ok ? S_READ_RD : S_FINISH;
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = S_PIX_RD;
                end
            end
            S_PIX_RD:
            begin
                priority if (visible)
                begin
                    state_next = S_PIX_WR;
                end
                else if (walk_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_PIX_RD;
                end
            end
            S_PIX_WR:    state_next = walk_last ? S_FINISH : S_PIX_RD;
            S_READ_RD:   state_next = S_READ_WAIT;
            S_READ_WAIT: state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath, memory commands and result register.
    always_comb
    begin
        sweep_next        = sweep_reg;
        sweep_item_next   = sweep_item_reg;
        fill_data_next    = fill_data_reg;
        pen_next          = pen_reg;
        walk_row_next     = walk_row_reg;
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        end_next          = end_reg;
        ya_next           = ya_reg;
        q_next            = q_reg;
        r_next            = r_reg;
        dx_next           = dx_reg;
        stepq_next        = stepq_reg;
        stepr_next        = stepr_reg;
        dy_neg_next       = dy_neg_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        read_byte_next    = read_byte_reg;
        mem_cmd.op        = MEM_NOP;
        mem_cmd.addr      = {cur_x_reg[COL_W-1:0], py[PAGE_W+2:3]};
        mem_cmd.data      = 8'(1) << py[2:0];
        mem_cmd.pen       = pen_reg;

        unique case (state_reg)
            S_SWEEP:
            begin
                mem_cmd.op   = MEM_WRITE;
                mem_cmd.addr = sweep_reg;
                mem_cmd.data = fill_data_reg;
                sweep_next   = sweep_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    // Default to a one-column walk on row ya with no slope.
                    pen_next      = pen;
                    result_next   = BYTE_EMPTY;
                    ya_next       = ya;
                    q_next        = '0;
                    r_next        = '0;
                    dx_next       = 8'd1;
                    stepq_next    = '0;
                    stepr_next    = '0;
                    walk_row_next = 1'b0;
                    cur_x_next    = xa;
                    cur_y_next    = ya;
                    end_next      = xa;
                    unique case (kind)
                        KIND_LINE:
                        begin
                            priority if (ya == yb)
                            begin
                                cur_x_next = x_lo;
                                end_next   = x_hi;
                            end
                            else if (xa == xb)
                            begin
                                walk_row_next = 1'b1;
                                cur_y_next    = y_lo;
                                end_next      = y_hi;
                            end
                            else
                            begin
                                // Walking from the far end starts at offset -dy.
                                cur_x_next  = x_lo;
                                end_next    = x_hi;
                                dx_next     = x_hi - x_lo;
                                dy_neg_next = dy_in[8];
                                q_next      = (xa < xb) ? 10'd0
                                              : (10'd0 - {dy_in[8], dy_in});
                            end
                        end
                        KIND_FILL:
                        begin
                            sweep_next      = '0;
                            sweep_item_next = 1'b1;
                            fill_data_next  = (pen == PEN_SET) ? BYTE_FULL : BYTE_EMPTY;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV:
            begin
                // Turn the magnitude quotient into a floor step for signed dy.
                if (div_res.done)
                begin
                    priority if (!dy_neg_reg)
                    begin
                        stepq_next = {2'b00, div_res.quo};
                        stepr_next = div_res.rem;
                    end
                    else if (div_res.rem == '0)
                    begin
                        stepq_next = 10'd0 - {2'b00, div_res.quo};
                        stepr_next = '0;
                    end
                    else
                    begin
                        stepq_next = 10'd0 - {2'b00, div_res.quo} - 10'd1;
                        stepr_next = dx_reg - div_res.rem;
                    end
                end
            end
            S_PIX_RD:
            begin
                priority if (visible)
                begin
                    mem_cmd.op = MEM_READ;
                end
                else if (!walk_last)
                begin
                    if (walk_row_reg)
                    begin
                        cur_y_next = cur_y_reg + 1'b1;
                    end
                    else
                    begin
                        cur_x_next = cur_x_reg + 1'b1;
                        q_next     = q_adv;
                        r_next     = r_adv;
                    end
                end
                else
                begin
                    mem_cmd.op = MEM_NOP;
                end
            end
            S_PIX_WR:
            begin
                mem_cmd.op = MEM_MODIFY;
                if (!walk_last)
                begin
                    if (walk_row_reg)
                    begin
                        cur_y_next = cur_y_reg + 1'b1;
                    end
                    else
                    begin
                        cur_x_next = cur_x_reg + 1'b1;
                        q_next     = q_adv;
                        r_next     = r_adv;
                    end
                end
            end
            S_READ_RD:
            begin
                mem_cmd.op   = MEM_READ;
                mem_cmd.addr = {cur_x_reg[COL_W-1:0], cur_y_reg[PAGE_W-1:0]};
            end
            S_READ_WAIT: result_next = rd_data;
            default: ;
        endcase

        // Hand the result to the output register once it is free.
        priority if ((state_reg == S_FINISH) && out_free)
        begin
            result_valid_next = 1'b1;
            read_byte_next    = result_reg;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_SWEEP;
            sweep_reg        <= '0;
            sweep_item_reg   <= 1'b0;
            fill_data_reg    <= BYTE_EMPTY;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            sweep_item_reg   <= sweep_item_next;
            fill_data_reg    <= fill_data_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pen_reg       <= pen_next;
        walk_row_reg  <= walk_row_next;
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        end_reg       <= end_next;
        ya_reg        <= ya_next;
        q_reg         <= q_next;
        r_reg         <= r_next;
        dx_reg        <= dx_next;
        stepq_reg     <= stepq_next;
        stepr_reg     <= stepr_next;
        dy_neg_reg    <= dy_neg_next;
        result_reg    <= result_next;
        read_byte_reg <= read_byte_next;
    end

    // A new result appears only when a finished transaction hands it over.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish");

    // Hold off new transactions for the cycle after one is taken.
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !item_ready)
        else $error("second transaction accepted while busy");

    // The divider reports only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_DIV))
        else $error("divider finished outside slope setup");

    // Issue no memory traffic while idle.
    a_idle_no_mem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (mem_cmd.op == MEM_NOP))
        else $error("memory access while idle");

endmodule

/* dv/tb.sv */
// Self-checking testbench for mono_framebuffer_point_line_draw_unit: points, lines,
// fills and page-byte reads against a shadow copy of the 128x64 page-organized frame.
// Depends on mfpl_pkg (kinds, pens, store geometry) and the draw unit RTL.
module tb
    import mfpl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_W   = 128;
    localparam int SCREEN_H   = 64;
    localparam int PAGE_COUNT = (SCREEN_H + 7) / 8;

    // Pen code 3 has no name in the package; when drawing it behaves as a clear.
    localparam logic [1:0] PEN_OTHER = 2'd3;

    // Cycles to linger after the last result: a full fill plus margin.
    localparam int SETTLE_CYCLES = 1100;
    localparam int RANDOM_CMDS   = 513;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] xa;
        logic [7:0] ya;
        logic [7:0] xb;
        logic [7:0] yb;
        logic [1:0] pen;
        bit         drain;   // hold this transaction until every result is back
    } draw_cmd_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic       item_ready;
    logic [1:0] kind         = KIND_POINT;
    logic [7:0] xa           = 8'd0;
    logic [7:0] ya           = 8'd0;
    logic [7:0] xb           = 8'd0;
    logic [7:0] yb           = 8'd0;
    logic [1:0] pen          = PEN_ERASE;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [7:0] read_byte;

    // Handshake outcomes latched at the rising edge, consumed at the falling edge.
    logic item_fire   = 1'b0;
    logic result_fire = 1'b0;

    draw_cmd_t  cmd_queue[$];
    logic [7:0] expected_read_bytes[$];
    logic [7:0] shadow_frame[STORE_DEPTH];

    int items_taken    = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int tx_wait        = 0;
    int rx_wait        = 0;

    mono_framebuffer_point_line_draw_unit #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .xa           (xa),
        .ya           (ya),
        .xb           (xb),
        .yb           (yb),
        .pen          (pen),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_byte    (read_byte)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Shadow frame: the expected contents of the page store
    // ------------------------------------------------------------------

    // Apply one pen to one pixel; drop anything off screen.
    function automatic void shadow_plot(int x, int y, logic [1:0] p);
        int         idx;
        logic [7:0] mask;
        if (x >= SCREEN_W || y >= SCREEN_H)
            return;
        idx  = (x * STORE_PAGES + (y >> 3)) & (STORE_DEPTH - 1);
        mask = 8'h01 << (y & 7);
        case (p)
            PEN_SET:    shadow_frame[idx] = shadow_frame[idx] | mask;
            PEN_INVERT: shadow_frame[idx] = shadow_frame[idx] ^ mask;
            default:    shadow_frame[idx] = shadow_frame[idx] & ~mask;
        endcase
    endfunction

    // Horizontal and vertical lines cover both endpoints. Sloped lines plot one
    // pixel per column with the row rounded toward minus infinity.
    function automatic void shadow_line(int x0, int y0, int x1, int y1, logic [1:0] p);
        int lo;
        int hi;
        int c;
        int dx;
        int dy;
        int num;
        int q;
        int y;
        if (y0 == y1) begin
            lo = (x0 < x1) ? x0 : x1;
            hi = (x0 < x1) ? x1 : x0;
            for (c = lo; c <= hi; c++)
                shadow_plot(c, y0, p);
        end
        else if (x0 == x1) begin
            lo = (y0 < y1) ? y0 : y1;
            hi = (y0 < y1) ? y1 : y0;
            for (c = lo; c <= hi; c++)
                shadow_plot(x0, c, p);
        end
        else begin
            dx = x1 - x0;
            dy = y1 - y0;
            lo = (x0 < x1) ? x0 : x1;
            hi = (x0 < x1) ? x1 : x0;
            if (dx < 0) begin
                dx = -dx;
                dy = -dy;
            end
            for (c = lo; c <= hi; c++) begin
                num = (c - x0) * dy;
                q   = num / dx;
                // Division truncates toward zero; push negatives down to the floor.
                if (num < 0 && (num % dx) != 0)
                    q = q - 1;
                y = y0 + q;
                if (y >= 0)
                    shadow_plot(c, y, p);
            end
        end
    endfunction

    // Advance the shadow frame by one transaction and return the byte it answers.
    function automatic logic [7:0] apply_draw_cmd(draw_cmd_t cmd);
        logic [7:0] answer;
        answer = BYTE_EMPTY;
        case (cmd.kind)
            KIND_POINT: shadow_plot(cmd.xa, cmd.ya, cmd.pen);
            KIND_LINE:  shadow_line(cmd.xa, cmd.ya, cmd.xb, cmd.yb, cmd.pen);
            KIND_FILL:
            begin
                // Invert and the spare pen leave the store alone.
                if (cmd.pen == PEN_SET)
                    foreach (shadow_frame[i]) shadow_frame[i] = BYTE_FULL;
                else if (cmd.pen == PEN_ERASE)
                    foreach (shadow_frame[i]) shadow_frame[i] = BYTE_EMPTY;
            end
            default:
            begin
                if (cmd.xa < SCREEN_W && cmd.ya < PAGE_COUNT && cmd.ya < STORE_PAGES)
                    answer = shadow_frame[(cmd.xa * STORE_PAGES + cmd.ya) & (STORE_DEPTH - 1)];
            end
        endcase
        return answer;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back, some short idles, a few long ones.
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // Bias columns toward a narrow strip so reads land on drawn bytes.
    function automatic logic [7:0] rand_col();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 8'($urandom_range(0, 15));
        if (r < 90)
            return 8'($urandom_range(0, SCREEN_W - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_row();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(0, SCREEN_H - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [1:0] rand_pen();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return PEN_ERASE;
        if (r < 7)
            return PEN_SET;
        if (r < 9)
            return PEN_INVERT;
        return PEN_OTHER;
    endfunction

    task automatic push_cmd(logic [1:0] k, logic [7:0] x0, logic [7:0] y0,
                            logic [7:0] x1, logic [7:0] y1, logic [1:0] p, bit drain);
        draw_cmd_t cmd;
        cmd.kind  = k;
        cmd.xa    = x0;
        cmd.ya    = y0;
        cmd.xb    = x1;
        cmd.yb    = y1;
        cmd.pen   = p;
        cmd.drain = drain;
        cmd_queue.push_back(cmd);
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued transactions on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        draw_cmd_t nxt;
        if (!rst_n) begin
            item_valid <= 1'b0;
        end
        else if (item_valid && !item_fire) begin
            // Hold valid and payload until the transaction is taken.
        end
        else if (tx_wait != 0) begin
            item_valid <= 1'b0;
            tx_wait = tx_wait - 1;
        end
        else if (cmd_queue.size() != 0 &&
                 !(cmd_queue[0].drain && expected_read_bytes.size() != 0)) begin
            nxt = cmd_queue.pop_front();
            kind       <= nxt.kind;
            xa         <= nxt.xa;
            ya         <= nxt.ya;
            xb         <= nxt.xb;
            yb         <= nxt.yb;
            pen        <= nxt.pen;
            item_valid <= 1'b1;
            // Gap to insert after this transaction; a stretch in the middle runs flat out.
            tx_wait = pick_gap(items_taken >= 200 && items_taken < 260);
        end
        else begin
            item_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: result_ready with random stalls and two long hold-offs
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (result_fire && (results_seen == 60 || results_seen == 380)) begin
                // Block the output long enough that the unit stalls with a result
                // held while the driver keeps offering the next transaction.
                rx_wait = 300;
            end
            else if (rx_wait == 0 && (result_fire || $urandom_range(0, 15) == 0)) begin
                rx_wait = pick_gap(results_seen >= 200 && results_seen < 260);
            end
            if (rx_wait != 0) begin
                result_ready <= 1'b0;
                rx_wait = rx_wait - 1;
            end
            else begin
                result_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted input, compare on accepted output
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        draw_cmd_t  seen;
        logic [7:0] want;
        item_fire   <= item_valid && item_ready;
        result_fire <= result_valid && result_ready;
        if (rst_n) begin
            if (item_valid && item_ready) begin
                seen.kind  = kind;
                seen.xa    = xa;
                seen.ya    = ya;
                seen.xb    = xb;
                seen.yb    = yb;
                seen.pen   = pen;
                seen.drain = 1'b0;
                expected_read_bytes.push_back(apply_draw_cmd(seen));
                items_taken++;
            end
            if (result_valid && result_ready) begin
                if (expected_read_bytes.size() == 0) begin
                    $display("%0t: result with nothing pending: expected none, actual %02h",
                             $time, read_byte);
                    mismatch_count++;
                end
                else begin
                    want = expected_read_bytes.pop_front();
                    if (read_byte !== want) begin
                        $display("%0t: read_byte of result %0d: expected %02h, actual %02h",
                                 $time, results_seen, want, read_byte);
                        mismatch_count++;
                    end
                end
                results_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int         n_cmds;
        int         r;
        logic [1:0] k;
        logic [7:0] x0;
        logic [7:0] y0;
        logic [7:0] x1;
        logic [7:0] y1;

        foreach (shadow_frame[i]) shadow_frame[i] = BYTE_EMPTY;

        // Directed: corners, off-screen pixels, every pen, each line shape, fills.
        push_cmd(KIND_READ,  8'd0,   8'd0,   8'd0,   8'd0,   PEN_ERASE,  1'b0);
        push_cmd(KIND_POINT, 8'd0,   8'd0,   8'd0,   8'd0,   PEN_SET,    1'b0);
        push_cmd(KIND_POINT, 8'd127, 8'd63,  8'd0,   8'd0,   PEN_SET,    1'b0);
        push_cmd(KIND_POINT, 8'd128, 8'd0,   8'd0,   8'd0,   PEN_SET,    1'b0);
        push_cmd(KIND_POINT, 8'd0,   8'd64,  8'd0,   8'd0,   PEN_SET,    1'b0);
        push_cmd(KIND_READ,  8'd0,   8'd0,   8'd0,   8'd0,   PEN_ERASE,  1'b0);
        push_cmd(KIND_READ,  8'd127, 8'd7,   8'd0,   8'd0,   PEN_ERASE,  1'b0);
        push_cmd(KIND_POINT, 8'd127, 8'd63,  8'd0,   8'd0,   PEN_INVERT, 1'b0);
        push_cmd(KIND_POINT, 8'd0,   8'd0,   8'd0,   8'd0,   PEN_OTHER,  1'b0);
        push_cmd(KIND_READ,  8'd127, 8'd7,   8'd0,   8'd0,   PEN_ERASE,  1'b0);
        push_cmd(KIND_LINE,  8'd0,   8'd5,   8'd255, 8'd5,   PEN_SET,    1'b0);
        push_cmd(KIND_LINE,  8'd10,  8'd10,  8'd10,  8'd10,  PEN_SET,    1'b0);
        push_cmd(KIND_LINE,  8'd3,   8'd0,   8'd3,   8'd255, PEN_INVERT, 1'b0);
        push_cmd(KIND_LINE,  8'd0,   8'd0,   8'd127, 8'd63,  PEN_SET,    1'b0);
        push_cmd(KIND_LINE,  8'd127, 8'd0,   8'd0,   8'd63,  PEN_INVERT, 1'b0);
        push_cmd(KIND_LINE,  8'd200, 8'd10,  8'd20,  8'd250, PEN_OTHER,  1'b0);
        push_cmd(KIND_READ,  8'd3,   8'd2,   8'd0,   8'd0,   PEN_ERASE,  1'b0);
        push_cmd(KIND_READ,  8'd128, 8'd0,   8'd0,   8'd0,   PEN_ERASE,  1'b0);
        push_cmd(KIND_READ,  8'd0,   8'd8,   8'd0,   8'd0,   PEN_ERASE,  1'b0);
        push_cmd(KIND_READ,  8'd255, 8'd255, 8'd255, 8'd255, PEN_OTHER,  1'b0);
        push_cmd(KIND_FILL,  8'd0,   8'd0,   8'd0,   8'd0,   PEN_OTHER,  1'b0);
        push_cmd(KIND_FILL,  8'd0,   8'd0,   8'd0,   8'd0,   PEN_INVERT, 1'b0);
        push_cmd(KIND_READ,  8'd64,  8'd4,   8'd0,   8'd0,   PEN_ERASE,  1'b0);
        push_cmd(KIND_FILL,  8'd0,   8'd0,   8'd0,   8'd0,   PEN_SET,    1'b0);
        push_cmd(KIND_READ,  8'd5,   8'd5,   8'd0,   8'd0,   PEN_ERASE,  1'b0);
        push_cmd(KIND_FILL,  8'd0,   8'd0,   8'd0,   8'd0,   PEN_ERASE,  1'b0);
        push_cmd(KIND_READ,  8'd5,   8'd5,   8'd0,   8'd0,   PEN_ERASE,  1'b0);

        // Random: mostly on-screen drawing and reads, rare fills, some wild values.
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            r  = $urandom_range(0, 99);
            x0 = rand_col();
            y0 = rand_row();
            x1 = 8'($urandom_range(0, 255));
            y1 = 8'($urandom_range(0, 255));
            if (r < 30) begin
                k = KIND_POINT;
            end
            else if (r < 58) begin
                k = KIND_LINE;
                r = $urandom_range(0, 9);
                if (r < 4) begin
                    // Short line near the start point; may wrap off screen.
                    x1 = 8'(x0 + $urandom_range(0, 16) - 8);
                    y1 = 8'(y0 + $urandom_range(0, 16) - 8);
                end
                else if (r < 6) begin
                    if ($urandom_range(0, 1) == 0) begin
                        x1 = rand_col();
                        y1 = y0;
                    end
                    else begin
                        x1 = x0;
                        y1 = rand_row();
                    end
                end
                else begin
                    x1 = rand_col();
                    y1 = rand_row();
                end
            end
            else if (r < 96) begin
                k  = KIND_READ;
                y0 = ($urandom_range(0, 99) < 90) ? 8'($urandom_range(0, PAGE_COUNT - 1))
                                                  : 8'($urandom_range(0, 255));
            end
            else begin
                k = KIND_FILL;
            end
            push_cmd(k, x0, y0, x1, y1,
                     (k == KIND_FILL) ? 2'($urandom_range(0, 3)) : rand_pen(),
                     n == 100 || n == 400);
        end
        n_cmds = cmd_queue.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every result, then linger to catch anything extra.
        while (results_seen != n_cmds)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Run limit: far above the worst case even if every transaction were a fill.
    initial
    begin
        #100_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
